// ===== design/stkw_pkg.sv =====
package stkw_pkg;

   localparam int DEPTH       = 16;
   localparam int DATA_W      = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int COUNT_OUT_W = 5;

   localparam logic signed [DATA_W-1:0] POP_EMPTY_VALUE = -1;

   typedef enum logic [1:0] {
      ACT_PUSH       = 2'd0,
      ACT_POP        = 2'd1,
      ACT_REMOVE     = 2'd2,
      ACT_REMOVE_EXT = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_DEL_HI,
      S_DEL_LO
   } state_type;

   typedef struct packed {
      action_type               action;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] popped_value;
      status_type               status;
      logic [COUNT_OUT_W-1:0]   entry_count_out;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

// ===== design/stack_with_value_removal.sv =====
// Push, pop and remove-value: the item is registered and executed in S_EXEC, which
// registers the result once the output register is free. Remove largest and smallest
// on a non-empty stack: top entry loaded, one scan step per entry below it, two
// removal steps; when empty it answers from S_EXEC. Items are taken only in S_IDLE.
// A finished result waits in the output register while the next item is taken.
// Reset empties the stack and the output register; cell contents are not cleared.
module stack_with_value_removal (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stkw_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stkw_pkg::rsp_type rsp_payload
);

   localparam int DEPTH  = stkw_pkg::DEPTH;
   localparam int DATA_W = stkw_pkg::DATA_W;
   localparam int IDX_W  = stkw_pkg::IDX_W;
   localparam int CNT_W  = stkw_pkg::CNT_W;

   stkw_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic signed [DATA_W-1:0] hi_ff, hi_in, lo_ff, lo_in;
   stkw_pkg::req_type   item_ff, item_in;
   stkw_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   stkw_pkg::cell_ctrl_type  ctrl [DEPTH];
   logic signed [DATA_W-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]         cell_match;
   logic signed [DATA_W-1:0] key;

   logic             accept;
   logic             out_free;
   logic             found;
   logic [IDX_W-1:0] match_idx;
   logic [CNT_W-1:0] count_m1;
   logic signed [DATA_W-1:0] scan_value;
   logic             emit;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == DEPTH - 1) begin : g_top
         stkw_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl[g]),
            .load_value  (item_ff.value),
            .upper_value (cell_value[g]),
            .key         (key),
            .value_out   (cell_value[g]),
            .match       (cell_match[g])
         );
      end else begin : g_mid
         stkw_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl[g]),
            .load_value  (item_ff.value),
            .upper_value (cell_value[g+1]),
            .key         (key),
            .value_out   (cell_value[g]),
            .match       (cell_match[g])
         );
      end
   end

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != stkw_pkg::S_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign count_m1   = count_ff - CNT_W'(1);
   assign scan_value = cell_value[idx_ff];
   assign key        = (state_ff == stkw_pkg::S_DEL_HI) ? hi_ff :
                       (state_ff == stkw_pkg::S_DEL_LO) ? lo_ff : item_ff.value;

   always_comb begin
      found     = 1'b0;
      match_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_match[i] && (CNT_W'(i) < count_ff)) begin
            found     = 1'b1;
            match_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      item_in      = accept ? req_payload : item_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      emit         = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         ctrl[i] = '0;
      end

      case (state_ff)
         stkw_pkg::S_IDLE: begin
            if (accept) begin
               state_in = stkw_pkg::S_EXEC;
            end
         end
         stkw_pkg::S_EXEC: begin
            case (item_ff.action)
               stkw_pkg::ACT_PUSH: begin
                  if (out_free) begin
                     emit                = 1'b1;
                     rsp_in.popped_value = '0;
                     if (count_ff >= CNT_W'(DEPTH)) begin
                        rsp_in.status = stkw_pkg::ST_FULL;
                     end else begin
                        rsp_in.status                   = stkw_pkg::ST_OK;
                        ctrl[count_ff[IDX_W-1:0]].load = 1'b1;
                        count_in                        = count_ff + CNT_W'(1);
                     end
                  end
               end
               stkw_pkg::ACT_POP: begin
                  if (out_free) begin
                     emit = 1'b1;
                     if (count_ff == '0) begin
                        rsp_in.popped_value = stkw_pkg::POP_EMPTY_VALUE;
                        rsp_in.status       = stkw_pkg::ST_EMPTY;
                     end else begin
                        rsp_in.popped_value = cell_value[count_m1[IDX_W-1:0]];
                        rsp_in.status       = stkw_pkg::ST_OK;
                        count_in            = count_m1;
                     end
                  end
               end
               stkw_pkg::ACT_REMOVE: begin
                  if (out_free) begin
                     emit                = 1'b1;
                     rsp_in.popped_value = '0;
                     if (count_ff == '0) begin
                        rsp_in.status = stkw_pkg::ST_EMPTY;
                     end else if (!found) begin
                        rsp_in.status = stkw_pkg::ST_NOT_FOUND;
                     end else begin
                        rsp_in.status = stkw_pkg::ST_OK;
                        for (int i = 0; i < DEPTH; i++) begin
                           ctrl[i].shift = (IDX_W'(i) >= match_idx) &&
                                           (CNT_W'(i + 1) < count_ff);
                        end
                        count_in = count_m1;
                     end
                  end
               end
               default: begin
                  if (count_ff == '0) begin
                     if (out_free) begin
                        emit                = 1'b1;
                        rsp_in.popped_value = '0;
                        rsp_in.status       = stkw_pkg::ST_EMPTY;
                     end
                  end else begin
                     hi_in = cell_value[count_m1[IDX_W-1:0]];
                     lo_in = cell_value[count_m1[IDX_W-1:0]];
                     if (count_ff == CNT_W'(1)) begin
                        state_in = stkw_pkg::S_DEL_HI;
                     end else begin
                        idx_in   = IDX_W'(count_ff - CNT_W'(2));
                        state_in = stkw_pkg::S_SCAN;
                     end
                  end
               end
            endcase
         end
         stkw_pkg::S_SCAN: begin
            if (scan_value > hi_ff) begin
               hi_in = scan_value;
            end
            if (scan_value < lo_ff) begin
               lo_in = scan_value;
            end
            if (idx_ff == '0) begin
               state_in = stkw_pkg::S_DEL_HI;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         stkw_pkg::S_DEL_HI: begin
            if (found) begin
               for (int i = 0; i < DEPTH; i++) begin
                  ctrl[i].shift = (IDX_W'(i) >= match_idx) &&
                                  (CNT_W'(i + 1) < count_ff);
               end
               count_in = count_m1;
            end
            state_in = stkw_pkg::S_DEL_LO;
         end
         stkw_pkg::S_DEL_LO: begin
            if (out_free) begin
               emit                = 1'b1;
               rsp_in.popped_value = '0;
               rsp_in.status       = stkw_pkg::ST_OK;
               if (found) begin
                  for (int i = 0; i < DEPTH; i++) begin
                     ctrl[i].shift = (IDX_W'(i) >= match_idx) &&
                                     (CNT_W'(i + 1) < count_ff);
                  end
                  count_in = count_m1;
               end
            end
         end
         default: begin
            state_in = stkw_pkg::S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_in.entry_count_out = stkw_pkg::COUNT_OUT_W'(count_in);
         rsp_valid_in           = 1'b1;
         state_in               = stkw_pkg::S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stkw_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == stkw_pkg::S_EXEC))
      else $error("transfer not followed by execute");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == stkw_pkg::S_DEL_HI) |=> (count_ff == $past(count_m1)))
      else $error("largest value not removed");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == stkw_pkg::S_SCAN) |-> (hi_ff >= lo_ff))
      else $error("scan bounds crossed");

endmodule

// ===== design/stkw_cell.sv =====
module stkw_cell (
   input  logic                               clock,
   input  stkw_pkg::cell_ctrl_type            ctrl,
   input  logic signed [stkw_pkg::DATA_W-1:0] load_value,
   input  logic signed [stkw_pkg::DATA_W-1:0] upper_value,
   input  logic signed [stkw_pkg::DATA_W-1:0] key,
   output logic signed [stkw_pkg::DATA_W-1:0] value_out,
   output logic                               match
);

   logic signed [stkw_pkg::DATA_W-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         value_ff <= load_value;
      end else if (ctrl.shift) begin
         value_ff <= upper_value;
      end
   end

   assign value_out = value_ff;
   assign match     = (value_ff == key);

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
   import stkw_pkg::*;

   localparam int DIRECTED_ROWS    = 19;
   localparam int RANDOM_ITEMS     = 1750;
   localparam int PHASES           = 12;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int DRAIN_CYCLES     = 40;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int LONG_HOLD_AFTER  = 600;

   typedef struct packed {
      action_type               action;
      logic signed [DATA_W-1:0] value;
      logic [4:0]               reps;
      logic signed [DATA_W-1:0] step;
      logic                     typed;
      logic signed [DATA_W-1:0] exp_popped;
      status_type               exp_status;
      logic [COUNT_OUT_W-1:0]   exp_count;
   } directed_step_type;

   directed_step_type plan [DIRECTED_ROWS] = '{
      '{ACT_POP,        32'sd0,           5'd1,  32'sd0, 1'b1, -32'sd1, ST_EMPTY,     5'd0},
      '{ACT_REMOVE,     32'sd0,           5'd1,  32'sd0, 1'b1, 32'sd0,  ST_EMPTY,     5'd0},
      '{ACT_REMOVE_EXT, 32'sd0,           5'd1,  32'sd0, 1'b1, 32'sd0,  ST_EMPTY,     5'd0},
      '{ACT_PUSH,       32'sh7FFFFFFF,    5'd1,  32'sd0, 1'b1, 32'sd0,  ST_OK,        5'd1},
      '{ACT_PUSH,       32'sh80000000,    5'd1,  32'sd0, 1'b1, 32'sd0,  ST_OK,        5'd2},
      '{ACT_REMOVE_EXT, 32'sd0,           5'd1,  32'sd0, 1'b1, 32'sd0,  ST_OK,        5'd0},
      '{ACT_PUSH,       32'sd5,           5'd1,  32'sd0, 1'b1, 32'sd0,  ST_OK,        5'd1},
      '{ACT_REMOVE_EXT, 32'sd0,           5'd1,  32'sd0, 1'b1, 32'sd0,  ST_OK,        5'd0},
      '{ACT_PUSH,       32'sd7,           5'd3,  32'sd0, 1'b0, 32'sd0,  ST_OK,        5'd0},
      '{ACT_REMOVE_EXT, 32'sd0,           5'd1,  32'sd0, 1'b0, 32'sd0,  ST_OK,        5'd0},
      '{ACT_REMOVE,     32'sd9,           5'd1,  32'sd0, 1'b1, 32'sd0,  ST_NOT_FOUND, 5'd1},
      '{ACT_REMOVE,     32'sd7,           5'd1,  32'sd0, 1'b1, 32'sd0,  ST_OK,        5'd0},
      '{ACT_PUSH,       -32'sd1,          5'd1,  32'sd0, 1'b1, 32'sd0,  ST_OK,        5'd1},
      '{ACT_POP,        32'sd0,           5'd1,  32'sd0, 1'b1, -32'sd1, ST_OK,        5'd0},
      '{ACT_PUSH,       32'sd100,         5'd16, 32'sd1, 1'b0, 32'sd0,  ST_OK,        5'd0},
      '{ACT_PUSH,       32'sd0,           5'd1,  32'sd0, 1'b1, 32'sd0,  ST_FULL,      5'd16},
      '{ACT_REMOVE,     32'sd107,         5'd1,  32'sd0, 1'b0, 32'sd0,  ST_OK,        5'd0},
      '{ACT_REMOVE_EXT, 32'sd0,           5'd1,  32'sd0, 1'b0, 32'sd0,  ST_OK,        5'd0},
      '{ACT_POP,        32'sd0,           5'd2,  32'sd0, 1'b0, 32'sd0,  ST_OK,        5'd0}
   };

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   logic signed [DATA_W-1:0] shadow_cells [DEPTH];
   int      shadow_count;
   rsp_type outstanding_results [$];
   int      mismatch_count;
   int      results_seen;
   int      quiet_cycles;
   int      sender_gap_max;
   int      receiver_wait_max;

   stack_with_value_removal u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit remove_topmost(logic signed [DATA_W-1:0] v);
      for (int i = shadow_count - 1; i >= 0; i--) begin
         if (shadow_cells[i] == v) begin
            for (int k = i; k + 1 < shadow_count; k++)
               shadow_cells[k] = shadow_cells[k + 1];
            shadow_count--;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic rsp_type apply_action(req_type item);
      rsp_type                  r;
      logic signed [DATA_W-1:0] hi;
      logic signed [DATA_W-1:0] lo;
      r.popped_value = '0;
      r.status       = ST_OK;
      case (item.action)
         ACT_PUSH: begin
            if (shadow_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_cells[shadow_count] = item.value;
               shadow_count++;
            end
         end
         ACT_POP: begin
            if (shadow_count == 0) begin
               r.popped_value = POP_EMPTY_VALUE;
               r.status       = ST_EMPTY;
            end else begin
               shadow_count--;
               r.popped_value = shadow_cells[shadow_count];
            end
         end
         ACT_REMOVE: begin
            if (shadow_count == 0)
               r.status = ST_EMPTY;
            else if (!remove_topmost(item.value))
               r.status = ST_NOT_FOUND;
         end
         default: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               hi = shadow_cells[0];
               lo = shadow_cells[0];
               for (int i = 1; i < shadow_count; i++) begin
                  if (shadow_cells[i] > hi)
                     hi = shadow_cells[i];
                  if (shadow_cells[i] < lo)
                     lo = shadow_cells[i];
               end
               void'(remove_topmost(hi));
               void'(remove_topmost(lo));
            end
         end
      endcase
      r.entry_count_out = COUNT_OUT_W'(shadow_count);
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(0, 5))
         0, 1: return int'($urandom_range(0, 8)) - 4;
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'sh80000000;
               1: return 32'sh7FFFFFFF;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_item(int push_share);
      req_type item;
      if ($urandom_range(0, 99) < push_share) begin
         item.action = ACT_PUSH;
      end else begin
         case ($urandom_range(0, 2))
            0: item.action = ACT_POP;
            1: item.action = ACT_REMOVE;
            default: item.action = ACT_REMOVE_EXT;
         endcase
      end
      item.value = random_value();
      if (item.action == ACT_REMOVE && shadow_count > 0 && $urandom_range(0, 3) != 0)
         item.value = shadow_cells[$urandom_range(0, shadow_count - 1)];
      return item;
   endfunction

   function automatic int pick_wait_max();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 3;
         default: return 10;
      endcase
   endfunction

   task automatic send_item(input req_type item, input bit typed, input rsp_type typed_rsp);
      int      gap;
      rsp_type predicted;
      gap = $urandom_range(0, sender_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      predicted = apply_action(item);
      outstanding_results.push_back(typed ? typed_rsp : predicted);
   endtask

   initial begin
      directed_step_type row;
      req_type      item;
      rsp_type      typed_rsp;
      int           push_share;
      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_payload       = '0;
      shadow_count      = 0;
      mismatch_count    = 0;
      results_seen      = 0;
      sender_gap_max    = 10;
      receiver_wait_max = 10;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = plan[r];
         for (int k = 0; k < row.reps; k++) begin
            item.action              = row.action;
            item.value               = row.value + row.step * k;
            typed_rsp.popped_value    = row.exp_popped;
            typed_rsp.status          = row.exp_status;
            typed_rsp.entry_count_out = row.exp_count;
            send_item(item, row.typed, typed_rsp);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         sender_gap_max    = pick_wait_max();
         receiver_wait_max = pick_wait_max();
         push_share        = $urandom_range(25, 70);
         if (p == PHASES / 2) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (outstanding_results.size() != 0) @(posedge clock);
         end
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            send_item(random_item(push_share), 1'b0, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int wait_cycles;
      bit long_hold_done;
      long_hold_done = 1'b0;
      rsp_stall      = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         wait_cycles = $urandom_range(0, receiver_wait_max);
         if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            wait_cycles    = LONG_HOLD_CYCLES;
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (outstanding_results.size() == 0) begin
            $error("unexpected result transfer: popped_value %0d status %0d count %0d",
                   rsp_payload.popped_value, rsp_payload.status,
                   rsp_payload.entry_count_out);
            mismatch_count++;
         end else begin
            want = outstanding_results.pop_front();
            if (rsp_payload.popped_value !== want.popped_value) begin
               $error("popped_value: expected %0d, got %0d",
                      want.popped_value, rsp_payload.popped_value);
               mismatch_count++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               mismatch_count++;
            end
            if (rsp_payload.entry_count_out !== want.entry_count_out) begin
               $error("entry_count_out: expected %0d, got %0d",
                      want.entry_count_out, rsp_payload.entry_count_out);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule
